@@ hw/rtl/gmms_pkg.sv @@
package gmms_pkg;

  // Sequencer step index and length of one node's program
  localparam int unsigned STEP_W    = 6;
  localparam int unsigned NUM_STEPS = 33;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

  localparam logic [31:0] SPACING_RESET = 32'd65536;

  typedef logic [1:0] axis_t;
  localparam axis_t AX_X = 2'd0;
  localparam axis_t AX_Y = 2'd1;
  localparam axis_t AX_Z = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    A_MASS,
    A_COORD,
    A_SPACING
  } a_sel_e;

  typedef enum logic [2:0] {
    B_VEL,
    B_P_LO,
    B_P_HI,
    B_D_LO,
    B_D_MID,
    B_D_HI
  } b_sel_e;

  typedef enum logic [1:0] {
    ACC_NOP,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_e;

  typedef enum logic [1:0] {
    SH_0,
    SH_32,
    SH_64
  } shift_e;

  typedef enum logic [1:0] {
    FIN_NONE,
    FIN_P,
    FIN_D,
    FIN_L
  } fin_e;

  typedef struct packed {
    a_sel_e  a_sel;
    axis_t   a_idx;
    b_sel_e  b_sel;
    axis_t   b_idx;
    acc_op_e acc_op;
    shift_e  shift;
    fin_e    fin;
    axis_t   dst;
  } mac_cmd_t;

  typedef struct packed {
    logic     capture;
    logic     emit;
    mac_cmd_t mac;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } dp_status_t;

  function automatic mac_cmd_t mk_cmd(a_sel_e a_sel, axis_t a_idx, b_sel_e b_sel,
                                      axis_t b_idx, acc_op_e acc_op, shift_e shift,
                                      fin_e fin, axis_t dst);
    mac_cmd_t c;
    c.a_sel  = a_sel;
    c.a_idx  = a_idx;
    c.b_sel  = b_sel;
    c.b_idx  = b_idx;
    c.acc_op = acc_op;
    c.shift  = shift;
    c.fin    = fin;
    c.dst    = dst;
    return c;
  endfunction

  function automatic mac_cmd_t nop_cmd();
    return mk_cmd(A_MASS, AX_X, B_VEL, AX_X, ACC_NOP, SH_0, FIN_NONE, AX_X);
  endfunction

  // Node program. Steps 0-2: momentum p = m*v. Then per angular component k
  // with axes (a,b): D = c_a*p_b - c_b*p_a over 32-bit halves of p, two idle
  // steps while D settles, then L = h*D over three limbs of D.
  // Components run in order z (x,y), x (y,z), y (z,x).
  function automatic mac_cmd_t step_cmd(logic [STEP_W-1:0] s);
    mac_cmd_t c;
    c = nop_cmd();
    case (s)
      6'd0:  c = mk_cmd(A_MASS, AX_X, B_VEL, AX_X, ACC_LOAD, SH_0, FIN_P, AX_X);
      6'd1:  c = mk_cmd(A_MASS, AX_X, B_VEL, AX_Y, ACC_LOAD, SH_0, FIN_P, AX_Y);
      6'd2:  c = mk_cmd(A_MASS, AX_X, B_VEL, AX_Z, ACC_LOAD, SH_0, FIN_P, AX_Z);
      // z component
      6'd4:  c = mk_cmd(A_COORD, AX_X, B_P_LO, AX_Y, ACC_LOAD, SH_0, FIN_NONE, AX_Z);
      6'd5:  c = mk_cmd(A_COORD, AX_X, B_P_HI, AX_Y, ACC_ADD, SH_32, FIN_NONE, AX_Z);
      6'd6:  c = mk_cmd(A_COORD, AX_Y, B_P_LO, AX_X, ACC_SUB, SH_0, FIN_NONE, AX_Z);
      6'd7:  c = mk_cmd(A_COORD, AX_Y, B_P_HI, AX_X, ACC_SUB, SH_32, FIN_D, AX_Z);
      6'd10: c = mk_cmd(A_SPACING, AX_X, B_D_LO, AX_X, ACC_LOAD, SH_0, FIN_NONE, AX_Z);
      6'd11: c = mk_cmd(A_SPACING, AX_X, B_D_MID, AX_X, ACC_ADD, SH_32, FIN_NONE, AX_Z);
      6'd12: c = mk_cmd(A_SPACING, AX_X, B_D_HI, AX_X, ACC_ADD, SH_64, FIN_L, AX_Z);
      // x component
      6'd13: c = mk_cmd(A_COORD, AX_Y, B_P_LO, AX_Z, ACC_LOAD, SH_0, FIN_NONE, AX_X);
      6'd14: c = mk_cmd(A_COORD, AX_Y, B_P_HI, AX_Z, ACC_ADD, SH_32, FIN_NONE, AX_X);
      6'd15: c = mk_cmd(A_COORD, AX_Z, B_P_LO, AX_Y, ACC_SUB, SH_0, FIN_NONE, AX_X);
      6'd16: c = mk_cmd(A_COORD, AX_Z, B_P_HI, AX_Y, ACC_SUB, SH_32, FIN_D, AX_X);
      6'd19: c = mk_cmd(A_SPACING, AX_X, B_D_LO, AX_X, ACC_LOAD, SH_0, FIN_NONE, AX_X);
      6'd20: c = mk_cmd(A_SPACING, AX_X, B_D_MID, AX_X, ACC_ADD, SH_32, FIN_NONE, AX_X);
      6'd21: c = mk_cmd(A_SPACING, AX_X, B_D_HI, AX_X, ACC_ADD, SH_64, FIN_L, AX_X);
      // y component
      6'd22: c = mk_cmd(A_COORD, AX_Z, B_P_LO, AX_X, ACC_LOAD, SH_0, FIN_NONE, AX_Y);
      6'd23: c = mk_cmd(A_COORD, AX_Z, B_P_HI, AX_X, ACC_ADD, SH_32, FIN_NONE, AX_Y);
      6'd24: c = mk_cmd(A_COORD, AX_X, B_P_LO, AX_Z, ACC_SUB, SH_0, FIN_NONE, AX_Y);
      6'd25: c = mk_cmd(A_COORD, AX_X, B_P_HI, AX_Z, ACC_SUB, SH_32, FIN_D, AX_Y);
      6'd28: c = mk_cmd(A_SPACING, AX_X, B_D_LO, AX_X, ACC_LOAD, SH_0, FIN_NONE, AX_Y);
      6'd29: c = mk_cmd(A_SPACING, AX_X, B_D_MID, AX_X, ACC_ADD, SH_32, FIN_NONE, AX_Y);
      6'd30: c = mk_cmd(A_SPACING, AX_X, B_D_HI, AX_X, ACC_ADD, SH_64, FIN_L, AX_Y);
      default: c = nop_cmd();
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/gmms_ctrl.sv @@
module gmms_ctrl
  import gmms_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (in_valid_i) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_q == LAST_STEP) begin
          step_d  = '0;
          state_d = status_i.last ? ST_EMIT : ST_IDLE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        step_d  = '0;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_stall_o    = 1'b1;
    cmd_o.capture = 1'b0;
    cmd_o.emit    = 1'b0;
    cmd_o.mac     = nop_cmd();
    case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_RUN: begin
        cmd_o.mac = step_cmd(step_q);
      end
      ST_EMIT: begin
        cmd_o.emit = status_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

@@ hw/rtl/gmms_dpath.sv @@
module gmms_dpath
  import gmms_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_cmd_t          cmd_i,
  output dp_status_t         status_o,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic signed [15:0] coord_x_i,
  input  logic signed [15:0] coord_y_i,
  input  logic signed [15:0] coord_z_i,
  input  logic [31:0]        node_mass_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] vel_z_i,
  input  logic               last_node_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [62:0]        total_mass_o,
  output logic signed [63:0] momentum_x_o,
  output logic signed [63:0] momentum_y_o,
  output logic signed [63:0] momentum_z_o,
  output logic signed [63:0] ang_mom_x_o,
  output logic signed [63:0] ang_mom_y_o,
  output logic signed [63:0] ang_mom_z_o
);

  typedef struct packed {
    acc_op_e acc_op;
    shift_e  shift;
    fin_e    fin;
    axis_t   dst;
  } acc_stage_t;

  typedef struct packed {
    fin_e  fin;
    axis_t dst;
  } fin_stage_t;

  function automatic logic signed [63:0] add_sat(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  logic [31:0]        spacing_q;
  logic signed [15:0] coord_q [3];
  logic [31:0]        mass_q;
  logic signed [31:0] vel_q [3];
  logic               last_q;

  logic signed [32:0]  op_a, op_b;
  logic signed [65:0]  prod_q;
  logic signed [127:0] term, acc_q, acc_d, acc_sh;
  logic signed [63:0]  p_q [3];
  logic [95:0]         d_q;
  logic signed [63:0]  p_new, l_sat, mom_sum, ang_sum;
  logic [63:0]         mass_sum;
  logic [62:0]         mass_acc_q;
  logic signed [63:0]  mom_acc_q [3];
  logic signed [63:0]  ang_acc_q [3];
  acc_stage_t          st1_q;
  fin_stage_t          st2_q;
  logic                out_valid_q;

  assign status_o.last     = last_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q <= SPACING_RESET;
    end else if (cfg_we_i) begin
      spacing_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      coord_q[AX_X] <= coord_x_i;
      coord_q[AX_Y] <= coord_y_i;
      coord_q[AX_Z] <= coord_z_i;
      mass_q        <= node_mass_i;
      vel_q[AX_X]   <= vel_x_i;
      vel_q[AX_Y]   <= vel_y_i;
      vel_q[AX_Z]   <= vel_z_i;
      last_q        <= last_node_i;
    end
  end

  // Operand select for the shared multiplier
  always_comb begin
    case (cmd_i.mac.a_sel)
      A_MASS:    op_a = {1'b0, mass_q};
      A_COORD:   op_a = {{17{coord_q[cmd_i.mac.a_idx][15]}}, coord_q[cmd_i.mac.a_idx]};
      A_SPACING: op_a = {1'b0, spacing_q};
      default:   op_a = '0;
    endcase
    case (cmd_i.mac.b_sel)
      B_VEL:   op_b = {vel_q[cmd_i.mac.b_idx][31], vel_q[cmd_i.mac.b_idx]};
      B_P_LO:  op_b = {1'b0, p_q[cmd_i.mac.b_idx][31:0]};
      B_P_HI:  op_b = {p_q[cmd_i.mac.b_idx][63], p_q[cmd_i.mac.b_idx][63:32]};
      B_D_LO:  op_b = {1'b0, d_q[31:0]};
      B_D_MID: op_b = {1'b0, d_q[63:32]};
      B_D_HI:  op_b = {d_q[95], d_q[95:64]};
      default: op_b = '0;
    endcase
  end

  // Align the registered product and accumulate
  always_comb begin
    case (st1_q.shift)
      SH_0:    term = {{62{prod_q[65]}}, prod_q};
      SH_32:   term = {{30{prod_q[65]}}, prod_q, 32'd0};
      SH_64:   term = {prod_q[63:0], 64'd0};
      default: term = '0;
    endcase
    case (st1_q.acc_op)
      ACC_LOAD: acc_d = term;
      ACC_ADD:  acc_d = acc_q + term;
      ACC_SUB:  acc_d = acc_q - term;
      default:  acc_d = acc_q;
    endcase
  end

  // Finish: floor shift, clamp L to 64 bits, saturating adds
  always_comb begin
    acc_sh = acc_q >>> FRAC_BITS;
    p_new  = acc_sh[63:0];
    if ((&acc_sh[127:63]) || !(|acc_sh[127:63])) begin
      l_sat = acc_sh[63:0];
    end else begin
      l_sat = acc_sh[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    mom_sum  = add_sat(mom_acc_q[st2_q.dst], p_new);
    ang_sum  = add_sat(ang_acc_q[st2_q.dst], l_sat);
    mass_sum = {1'b0, mass_acc_q} + {32'd0, node_mass_i};
  end

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    acc_q  <= acc_d;
    case (st2_q.fin)
      FIN_P:   p_q[st2_q.dst] <= p_new;
      FIN_D:   d_q <= acc_q[95:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_q <= '{acc_op: ACC_NOP, shift: SH_0, fin: FIN_NONE, dst: AX_X};
      st2_q <= '{fin: FIN_NONE, dst: AX_X};
    end else begin
      st1_q <= '{acc_op: cmd_i.mac.acc_op, shift: cmd_i.mac.shift,
                 fin: cmd_i.mac.fin, dst: cmd_i.mac.dst};
      st2_q <= '{fin: st1_q.fin, dst: st1_q.dst};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_acc_q <= '0;
      for (int i = 0; i < 3; i++) begin
        mom_acc_q[i] <= '0;
        ang_acc_q[i] <= '0;
      end
    end else if (cmd_i.emit) begin
      mass_acc_q <= '0;
      for (int i = 0; i < 3; i++) begin
        mom_acc_q[i] <= '0;
        ang_acc_q[i] <= '0;
      end
    end else begin
      if (cmd_i.capture) begin
        mass_acc_q <= mass_sum[63] ? {63{1'b1}} : mass_sum[62:0];
      end
      case (st2_q.fin)
        FIN_P:   mom_acc_q[st2_q.dst] <= mom_sum;
        FIN_L:   ang_acc_q[st2_q.dst] <= ang_sum;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      total_mass_o <= mass_acc_q;
      momentum_x_o <= mom_acc_q[AX_X];
      momentum_y_o <= mom_acc_q[AX_Y];
      momentum_z_o <= mom_acc_q[AX_Z];
      ang_mom_x_o  <= ang_acc_q[AX_X];
      ang_mom_y_o  <= ang_acc_q[AX_Y];
      ang_mom_z_o  <= ang_acc_q[AX_Z];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hw/rtl/grid_mass_momentum_sum_core.sv @@
// Channel   Direction  Handshake                Payload
// config    in         cfg_we_i                 cfg_wdata_i (grid spacing h, Q.F)
// node      in         in_valid_i / in_stall_o  coord_x/y/z, node_mass, vel_x/y/z, last_node
// totals    out        out_valid_o / out_stall_i total_mass, momentum_x/y/z, ang_mom_x/y/z
//
// Each node is captured and then runs a 33-step program on the single shared
// 33x33 multiplier (24 products with settle gaps between dependent products)
// before the next transfer is possible. After a last node the sequencer also
// emits, waiting while a previous result still sits stalled at the output.
// Reset is asynchronous: spacing returns to 65536, running totals to zero.
// The output register holds one result, so a node is taken while it waits.
module grid_mass_momentum_sum_core
  import gmms_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] coord_x_i,
  input  logic signed [15:0] coord_y_i,
  input  logic signed [15:0] coord_z_i,
  input  logic [31:0]        node_mass_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] vel_z_i,
  input  logic               last_node_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [62:0]        total_mass_o,
  output logic signed [63:0] momentum_x_o,
  output logic signed [63:0] momentum_y_o,
  output logic signed [63:0] momentum_z_o,
  output logic signed [63:0] ang_mom_x_o,
  output logic signed [63:0] ang_mom_y_o,
  output logic signed [63:0] ang_mom_z_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer: walks the node program and gates capture and emit
  gmms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: multiplier, 128-bit accumulator, saturating totals, output register
  gmms_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .coord_x_i    (coord_x_i),
    .coord_y_i    (coord_y_i),
    .coord_z_i    (coord_z_i),
    .node_mass_i  (node_mass_i),
    .vel_x_i      (vel_x_i),
    .vel_y_i      (vel_y_i),
    .vel_z_i      (vel_z_i),
    .last_node_i  (last_node_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .total_mass_o (total_mass_o),
    .momentum_x_o (momentum_x_o),
    .momentum_y_o (momentum_y_o),
    .momentum_z_o (momentum_z_o),
    .ang_mom_x_o  (ang_mom_x_o),
    .ang_mom_y_o  (ang_mom_y_o),
    .ang_mom_z_o  (ang_mom_z_o)
  );

  // Never overwrite a result that is still stalled at the output
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> status.out_free)
    else $error("emit while output register occupied");

  // An emit always presents a result on the next cycle
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> out_valid_o)
    else $error("emit did not raise out_valid_o");

  // Only a node flagged last produces a result
  a_emit_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> status.last)
    else $error("emit without last node");

  // Once a node is captured, hold off the next transfer while it is processed
  a_capture_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> in_stall_o)
    else $error("input not stalled after capture");

endmodule
